// ===== design/idtw_pkg.sv =====
// ============================================================================
// idtw_pkg
// Shared sizes, command and status codes and the map entry layout of the
// idle-connection timing wheel.
// ============================================================================
package idtw_pkg;

    // Wheel geometry and connection id space
    localparam int SLOTS        = 8;
    localparam int SLOT_ENTRIES = 16;
    localparam int MAX_CONN     = 1024;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int ID_W     = 10;
    localparam int STATUS_W = 3;

    // Derived sizes
    localparam int NLOC    = SLOTS * SLOT_ENTRIES;
    localparam int LOC_W   = $clog2(NLOC);
    localparam int PTR_W   = $clog2(SLOTS);
    localparam int ENTRY_W = (SLOT_ENTRIES > 1) ? $clog2(SLOT_ENTRIES) : 1;
    localparam int MAP_AW  = (MAX_CONN > 1) ? $clog2(MAX_CONN) : 1;
    localparam int CMP_W   = 18;

    // Stream word widths
    localparam int S_TDATA_W = ((CMD_W + ID_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STATUS_W + ID_W + 7) / 8) * 8;

    // Commands
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REFRESH = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXPIRED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY_TICK = 3'd4;

    // One connection map entry: held flag and wheel location
    typedef struct packed {
        logic             valid;
        logic [LOC_W-1:0] loc;
    } map_entry_t;

endpackage

// ===== design/idle_timeout_timing_wheel.sv =====
// ============================================================================
// idle_timeout_timing_wheel
// Timing wheel that tracks idle connections and reports the ones that expire.
// ============================================================================
// After reset the block sweeps its connection map, one entry a cycle,
// through all MAX_CONN (1024) entries and takes no word meanwhile. Each
// input word is then worked on alone, entry by entry, by one slot scanner,
// and no new word is taken until that work is done. The steps per word:
// - An add or refresh reads the map, checks it, then searches the slot
//   behind the pointer. The search ends at the first free entry, or after the
//   last entry when the slot is full.
// - A refresh of an unknown connection ends after the map check.
// - A tick moves the pointer, then scans the new slot entry by entry and
//   reports each expired connection. The scan stops at the last occupied
//   entry, or covers the whole slot when it is empty.
// - An ignored command is dropped without a result.
// The slot store and the map each have one registered read port. Results
// leave through an output register. Any step that produces a result holds
// while the previous result still waits there.
module idle_timeout_timing_wheel
    import idtw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [1:0] command, [11:2] conn_id
    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [2:0] status, [12:3] conn_id (expired_id on expiry)
    output logic                 m_tlast
);

    // Sequencer states
    localparam logic [2:0] ST_CLEAR     = 3'd0;
    localparam logic [2:0] ST_IDLE      = 3'd1;
    localparam logic [2:0] ST_MAP_RD    = 3'd2;
    localparam logic [2:0] ST_MAP_CHK   = 3'd3;
    localparam logic [2:0] ST_PLACE     = 3'd4;
    localparam logic [2:0] ST_TICK_SCAN = 3'd5;
    localparam logic [2:0] ST_TICK_EMIT = 3'd6;

    localparam logic [ENTRY_W-1:0] ENTRY_LAST = ENTRY_W'(SLOT_ENTRIES - 1);
    localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(SLOTS - 1);
    localparam logic [MAP_AW-1:0]  MAP_LAST   = MAP_AW'(MAX_CONN - 1);

    // Control state
    logic [2:0]         state_reg, state_next;
    logic [ENTRY_W-1:0] e_reg, e_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [MAP_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [NLOC-1:0]    valid_reg, valid_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [ID_W-1:0]    id_reg, id_next;

    // Output register
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [ID_W-1:0]     m_id_reg;
    logic                m_last_reg;

    // Memories
    logic [ID_W-1:0] store_id_mem [NLOC];
    map_entry_t      map_mem [MAX_CONN];
    logic [ID_W-1:0] id_rdata_reg;
    map_entry_t      map_rdata_reg;

    // Datapath and control signals
    logic                s_acc;
    logic                out_free;
    logic [PTR_W-1:0]    place_slot;
    logic [PTR_W-1:0]    scan_slot;
    logic [LOC_W-1:0]    scan_loc;
    logic [SLOT_ENTRIES-1:0] slot_vec;
    logic                cur_valid;
    logic                rest_any;
    logic                id_in_range;
    logic                gone_in_range;
    logic                map_we;
    logic [MAP_AW-1:0]   map_waddr;
    map_entry_t          map_wdata;
    logic                id_we;
    logic                emit;
    logic [STATUS_W-1:0] emit_status;
    logic [ID_W-1:0]     emit_id;
    logic                emit_last;

    assign s_acc    = s_tvalid & s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = ~m_tvalid_reg | m_tready;

    // Pick the slot under scan: behind the pointer for placing, at it for ticks
    assign place_slot = (ptr_reg == '0) ? PTR_LAST : PTR_W'(ptr_reg - 1'b1);
    assign scan_slot  = (state_reg == ST_PLACE) ? place_slot : ptr_reg;
    assign scan_loc   = LOC_W'(LOC_W'(scan_slot) * LOC_W'(SLOT_ENTRIES) + LOC_W'(e_reg));

    // Gather the valid bits of the scanned slot
    always_comb begin
        for (int k = 0; k < SLOT_ENTRIES; k++) begin
            slot_vec[k] = valid_reg[LOC_W'(LOC_W'(scan_slot) * LOC_W'(SLOT_ENTRIES)
                                           + LOC_W'(k))];
        end
    end

    assign cur_valid = slot_vec[e_reg];

    // Look ahead for any occupied entry after the current one
    always_comb begin
        rest_any = 1'b0;
        for (int k = 0; k < SLOT_ENTRIES; k++) begin
            if ((ENTRY_W'(k) > e_reg) && slot_vec[k]) begin
                rest_any = 1'b1;
            end
        end
    end

    assign id_in_range   = (CMP_W'(id_reg) < CMP_W'(MAX_CONN));
    assign gone_in_range = (CMP_W'(id_rdata_reg) < CMP_W'(MAX_CONN));

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        e_next       = e_reg;
        ptr_next     = ptr_reg;
        clr_cnt_next = clr_cnt_reg;
        valid_next   = valid_reg;
        cmd_next     = cmd_reg;
        id_next      = id_reg;
        map_we       = 1'b0;
        map_waddr    = MAP_AW'(id_reg);
        map_wdata    = '0;
        id_we        = 1'b0;
        emit         = 1'b0;
        emit_status  = ST_OK;
        emit_id      = id_reg;
        emit_last    = 1'b1;

        case (state_reg)
            ST_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = clr_cnt_reg;
                if (clr_cnt_reg == MAP_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    cmd_next = s_tdata[CMD_W-1:0];
                    id_next  = s_tdata[CMD_W+ID_W-1:CMD_W];
                    e_next   = '0;
                    case (s_tdata[CMD_W-1:0])
                        CMD_TICK: begin
                            ptr_next   = (ptr_reg == PTR_LAST) ? '0
                                                               : PTR_W'(ptr_reg + 1'b1);
                            state_next = ST_TICK_SCAN;
                        end
                        CMD_ADD, CMD_REFRESH: begin
                            state_next = ST_MAP_RD;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MAP_RD: begin
                state_next = ST_MAP_CHK;
            end
            ST_MAP_CHK: begin
                if (!id_in_range || (cmd_reg == CMD_REFRESH && !map_rdata_reg.valid)) begin
                    if (out_free) begin
                        emit        = 1'b1;
                        emit_status = ST_UNKNOWN;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    // drop the old entry before placing again
                    if (map_rdata_reg.valid) begin
                        valid_next[map_rdata_reg.loc] = 1'b0;
                    end
                    e_next     = '0;
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                if (!cur_valid) begin
                    if (out_free) begin
                        valid_next[scan_loc] = 1'b1;
                        id_we                = 1'b1;
                        map_we               = 1'b1;
                        map_wdata.valid      = 1'b1;
                        map_wdata.loc        = scan_loc;
                        emit                 = 1'b1;
                        emit_status          = ST_OK;
                        state_next           = ST_IDLE;
                    end
                end else if (e_reg == ENTRY_LAST) begin
                    if (out_free) begin
                        map_we      = 1'b1;
                        emit        = 1'b1;
                        emit_status = ST_FULL;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    e_next = e_reg + 1'b1;
                end
            end
            ST_TICK_SCAN: begin
                if (cur_valid) begin
                    state_next = ST_TICK_EMIT;
                end else if (e_reg == ENTRY_LAST) begin
                    // nothing held in the new slot
                    if (out_free) begin
                        emit        = 1'b1;
                        emit_status = ST_EMPTY_TICK;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    e_next = e_reg + 1'b1;
                end
            end
            ST_TICK_EMIT: begin
                if (out_free) begin
                    valid_next[scan_loc] = 1'b0;
                    map_we               = gone_in_range;
                    map_waddr            = MAP_AW'(id_rdata_reg);
                    emit                 = 1'b1;
                    emit_status          = ST_EXPIRED;
                    emit_id              = id_rdata_reg;
                    emit_last            = ~rest_any;
                    if (rest_any) begin
                        e_next     = e_reg + 1'b1;
                        state_next = ST_TICK_SCAN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            ptr_reg     <= '0;
            valid_reg   <= '0;
            e_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            ptr_reg     <= ptr_next;
            valid_reg   <= valid_next;
            e_reg       <= e_next;
        end
    end

    // Captured input word
    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        id_reg  <= id_next;
    end

    // Slot store ids: one write, one registered read
    always_ff @(posedge aclk) begin
        if (id_we) begin
            store_id_mem[scan_loc] <= id_reg;
        end
        id_rdata_reg <= store_id_mem[scan_loc];
    end

    // Connection map: one write, one registered read
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rdata_reg <= map_mem[MAP_AW'(id_reg)];
    end

    // Hold a result until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_status_reg <= emit_status;
            m_id_reg     <= emit_id;
            m_last_reg   <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = M_TDATA_W'({m_id_reg, m_status_reg});

    // Pointer moves only on an accepted tick
    a_ptr_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (ptr_reg != $past(ptr_reg)))
            |-> $past(s_acc && (s_tdata[CMD_W-1:0] == CMD_TICK)))
        else $error("wheel pointer moved without a tick");

    // Expiries come only from tick work
    a_expire_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && (emit_status == ST_EXPIRED)) |-> (cmd_reg == CMD_TICK))
        else $error("expiry reported outside a tick");

    // Never overwrite a result still waiting at the output
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result register overwritten");

    // The expiry step always works on an occupied entry
    a_emit_occupied: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TICK_EMIT) |-> cur_valid)
        else $error("expiring a free entry");

    // An empty tick is a single final result
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_status_reg == ST_EMPTY_TICK)) |-> m_last_reg)
        else $error("empty tick result not marked last");

endmodule
